// ----- hw/rtl/wmalu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmalu_pkg
// shared types and constants of the width masked integer alu
// ----------------------------------------------------------------------------
package wmalu_pkg;

	localparam int MAX_WIDTH = 64;
	localparam int WW        = 7;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_AND = 4'd4;
	localparam logic [3:0] OP_OR  = 4'd5;
	localparam logic [3:0] OP_NOR = 4'd6;
	localparam logic [3:0] OP_XOR = 4'd7;
	localparam logic [3:0] OP_SHL = 4'd8;
	localparam logic [3:0] OP_SHR = 4'd9;
	localparam logic [3:0] OP_ROL = 4'd10;
	localparam logic [3:0] OP_ROR = 4'd11;
	localparam logic [3:0] OP_MOD = 4'd12;
	localparam logic [3:0] OP_NOT = 4'd13;
	localparam logic [3:0] OP_NEG = 4'd14;

	typedef enum logic [2:0] {
		CLS_FAST,
		CLS_MUL,
		CLS_DIV,
		CLS_MOD,
		CLS_ROL,
		CLS_ROR
	} cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [3:0]           op;
		cls_t                 cls;
		logic [WW-1:0]        width;
		logic [MAX_WIDTH-1:0] mask;
		logic [MAX_WIDTH-1:0] a;
		logic [MAX_WIDTH-1:0] b;
	} entry_t;

	typedef struct packed {
		logic full;
		logic head_valid;
	} qstat_t;

endpackage

// ----- hw/rtl/wmalu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmalu_front
// masks operands to the word width and classifies the opcode
// ----------------------------------------------------------------------------
module wmalu_front import wmalu_pkg::*; (
	input  logic [3:0]           opcode,
	input  logic [MAX_WIDTH-1:0] right_operand,
	input  logic [MAX_WIDTH-1:0] left_operand,
	input  logic [WW-1:0]        width_cfg,
	output entry_t               entry
);

	logic [WW-1:0]        eff_w;
	logic [MAX_WIDTH-1:0] mask;

	always_comb begin
		if (width_cfg == '0 || width_cfg > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = width_cfg;
		end
		mask = ~({MAX_WIDTH{1'b1}} << eff_w);
	end

	always_comb begin
		entry.op    = opcode;
		entry.width = eff_w;
		entry.mask  = mask;
		entry.a     = right_operand & mask;
		entry.b     = left_operand & mask;
		case (opcode)
			OP_MUL:  entry.cls = CLS_MUL;
			OP_DIV:  entry.cls = CLS_DIV;
			OP_MOD:  entry.cls = CLS_MOD;
			OP_ROL:  entry.cls = CLS_ROL;
			OP_ROR:  entry.cls = CLS_ROR;
			default: entry.cls = CLS_FAST;
		endcase
	end

endmodule

// ----- hw/rtl/wmalu_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmalu_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module wmalu_queue import wmalu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head_entry,
	output qstat_t stat
);

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	assign head_entry      = mem_q[rd_q];
	assign stat.full       = (cnt_q == (QAW+1)'(QDEPTH));
	assign stat.head_valid = (cnt_q != '0);

endmodule

// ----- hw/rtl/wmalu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmalu_back
// executes words: combinational ops, sequential multiply and shared divider
// ----------------------------------------------------------------------------
module wmalu_back import wmalu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  entry_t               head_entry,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [MAX_WIDTH-1:0] result
);

	localparam int CW = $clog2(MAX_WIDTH);

	state_t               state_q, state_d;
	cls_t                 cls_q;
	logic [WW-1:0]        width_q;
	logic [MAX_WIDTH-1:0] mask_q;
	logic [MAX_WIDTH-1:0] n_q, d_q, rem_q, p_q;
	logic                 nneg_q, dneg_q;
	logic [CW-1:0]        cnt_q;
	logic                 out_valid_q;
	logic [MAX_WIDTH-1:0] result_q;

	logic                 load_ok, load_out;
	logic [MAX_WIDTH-1:0] fast_r, fin_r, out_d;
	logic                 start;
	logic                 nneg, dneg;
	logic [MAX_WIDTH-1:0] nm, dm;
	logic [MAX_WIDTH:0]   rem_sh;
	logic                 ge;
	logic [CW-1:0]        rot;
	logic [WW-1:0]        rot_back;
	logic [MAX_WIDTH-1:0] q_fix, r_fix, rot_r;

	assign load_ok = !out_valid_q || !out_stall;

	// combinational operations straight from the queue head
	always_comb begin
		case (head_entry.op)
			OP_ADD: fast_r = head_entry.b + head_entry.a;
			OP_SUB: fast_r = head_entry.b - head_entry.a;
			OP_AND: fast_r = head_entry.b & head_entry.a;
			OP_OR:  fast_r = head_entry.b | head_entry.a;
			OP_NOR: fast_r = ~(head_entry.b | head_entry.a);
			OP_XOR: fast_r = head_entry.b ^ head_entry.a;
			OP_SHL: fast_r = (head_entry.a >= MAX_WIDTH) ? '0 :
					head_entry.b << head_entry.a[CW-1:0];
			OP_SHR: fast_r = (head_entry.a >= MAX_WIDTH) ? '0 :
					head_entry.b >> head_entry.a[CW-1:0];
			OP_NOT: fast_r = ~head_entry.a;
			OP_NEG: fast_r = ~head_entry.a + 1'b1;
			default: fast_r = '0;
		endcase
	end

	// divider operands: signed magnitudes, or count and width for rotates
	always_comb begin
		nneg = head_entry.b[MAX_WIDTH-1];
		dneg = head_entry.a[MAX_WIDTH-1];
		nm   = nneg ? (~head_entry.b + 1'b1) : head_entry.b;
		dm   = dneg ? (~head_entry.a + 1'b1) : head_entry.a;
	end

	// one restoring step
	assign rem_sh = {rem_q, n_q[MAX_WIDTH-1]};
	assign ge     = (rem_sh >= {1'b0, d_q});

	// finishing step
	always_comb begin
		q_fix    = (nneg_q != dneg_q) ? (~n_q + 1'b1) : n_q;
		r_fix    = nneg_q ? (~rem_q + 1'b1) : rem_q;
		rot      = rem_q[CW-1:0];
		rot_back = width_q - {1'b0, rot};
		if (rot == '0) begin
			rot_r = p_q;
		end else if (cls_q == CLS_ROL) begin
			rot_r = (p_q << rot) | (p_q >> rot_back);
		end else begin
			rot_r = (p_q >> rot) | (p_q << rot_back);
		end
		case (cls_q)
			CLS_MUL: fin_r = rem_q + {p_q[MAX_WIDTH/2-1:0], {(MAX_WIDTH/2){1'b0}}};
			CLS_DIV: fin_r = (d_q == '0) ? '0 : q_fix;
			CLS_MOD: fin_r = (d_q == '0) ? '0 : r_fix;
			CLS_ROL: fin_r = rot_r;
			CLS_ROR: fin_r = rot_r;
			default: fin_r = '0;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		start    = 1'b0;
		load_out = 1'b0;
		out_d    = fin_r & mask_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					if (head_entry.cls == CLS_FAST) begin
						if (load_ok) begin
							pop      = 1'b1;
							load_out = 1'b1;
							out_d    = fast_r & head_entry.mask;
						end
					end else begin
						pop   = 1'b1;
						start = 1'b1;
						state_d = (head_entry.cls == CLS_MUL) ? ST_MUL : ST_DIV;
					end
				end
			end
			ST_MUL: begin
				if (cnt_q == CW'(2)) state_d = ST_FIN;
			end
			ST_DIV: begin
				if (cnt_q == CW'(MAX_WIDTH-1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (load_ok) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start || state_q == ST_FIN) begin
				cnt_q <= '0;
			end else if (state_q == ST_MUL || state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) result_q <= out_d;
		if (start) begin
			cls_q   <= head_entry.cls;
			width_q <= head_entry.width;
			mask_q  <= head_entry.mask;
			rem_q   <= '0;
			p_q     <= head_entry.b;
			case (head_entry.cls)
				CLS_DIV, CLS_MOD: begin
					n_q    <= nm;
					d_q    <= dm;
					nneg_q <= nneg;
					dneg_q <= dneg;
				end
				CLS_MUL: begin
					n_q    <= head_entry.a;
					d_q    <= head_entry.b;
					nneg_q <= 1'b0;
					dneg_q <= 1'b0;
				end
				default: begin
					// rotate: count modulo width, value kept in p_q
					n_q    <= head_entry.a;
					d_q    <= MAX_WIDTH'(head_entry.width);
					nneg_q <= 1'b0;
					dneg_q <= 1'b0;
				end
			endcase
		end else if (state_q == ST_MUL) begin
			case (cnt_q)
				CW'(0): p_q <= n_q[MAX_WIDTH/2-1:0] * d_q[MAX_WIDTH/2-1:0];
				CW'(1): begin
					rem_q <= p_q;
					p_q   <= n_q[MAX_WIDTH/2-1:0] * d_q[MAX_WIDTH-1:MAX_WIDTH/2];
				end
				default: begin
					rem_q <= rem_q + {p_q[MAX_WIDTH/2-1:0], {(MAX_WIDTH/2){1'b0}}};
					p_q   <= n_q[MAX_WIDTH-1:MAX_WIDTH/2] * d_q[MAX_WIDTH/2-1:0];
				end
			endcase
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? MAX_WIDTH'(rem_sh - {1'b0, d_q}) : rem_sh[MAX_WIDTH-1:0];
			n_q   <= {n_q[MAX_WIDTH-2:0], ge};
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// ----- hw/rtl/width_masked_integer_alu_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// width_masked_integer_alu_unit
// integer alu with a programmable word width of 1 to 64 bits
// ----------------------------------------------------------------------------
// each input word carries an opcode, a right operand and a left operand; both
// operands and the result are masked to word_width (0 or above 64 acts as 64).
// the front masks and classifies words into a four deep queue, the back runs
// them in order into an output register. add, sub, logic ops, shifts, not and
// negate come straight from the queue head and stream at one word a cycle
// while the output is not stalled. multiply reuses one 32x32 multiplier
// three times. divide, modulo and rotates go through a bit serial restoring
// divider (the rotate count is reduced modulo the width there).
// divide or modulo by zero returns 0, shifts of 64 or more return 0.
// ----------------------------------------------------------------------------
module width_masked_integer_alu_unit import wmalu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 word_width_we,
	input  logic [WW-1:0]        word_width,
	// input words
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [3:0]           opcode,
	input  logic [MAX_WIDTH-1:0] right_operand,
	input  logic [MAX_WIDTH-1:0] left_operand,
	// result words
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [MAX_WIDTH-1:0] result
);

	logic [WW-1:0] width_q;
	entry_t        front_entry;
	entry_t        head_entry;
	qstat_t        qstat;
	logic          push;
	logic          pop;

	// word width register, resets to the full 64 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WW'(MAX_WIDTH);
		end else if (word_width_we) begin
			width_q <= word_width;
		end
	end

	// front: accept while the queue has room
	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	wmalu_front u_front (
		.opcode        (opcode),
		.right_operand (right_operand),
		.left_operand  (left_operand),
		.width_cfg     (width_q),
		.entry         (front_entry)
	);

	wmalu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.stat       (qstat)
	);

	// back: executes in order, holds the finished word in its output register
	wmalu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (qstat.head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

endmodule

// ----- tb/sv/tb_width_masked_integer_alu_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_width_masked_integer_alu_unit
// self checking bench for the width masked integer alu
// ----------------------------------------------------------------------------
// a directed table of words is driven first, some rows with typed in results,
// then random words over several word widths. for every accepted word the
// typed in result, or else the result of a local alu model, is queued;
// each accepted result word is compared with the oldest queued value. both
// sides idle at random, and the receiver holds off once for a long stretch so
// the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_width_masked_integer_alu_unit;
	import wmalu_pkg::*;

	localparam int IDLE_PCT = 34;

	logic                 clk;
	logic                 arst_n;
	logic                 word_width_we;
	logic [WW-1:0]        word_width;
	logic                 in_valid;
	logic                 in_stall;
	logic [3:0]           opcode;
	logic [MAX_WIDTH-1:0] right_operand;
	logic [MAX_WIDTH-1:0] left_operand;
	logic                 out_valid;
	logic                 out_stall;
	logic [MAX_WIDTH-1:0] result;

	// operation word as held in the directed table
	typedef struct {
		logic [3:0]  op;
		logic [63:0] rhs;
		logic [63:0] lhs;
		bit          fixed;
		logic [63:0] want;
	} alu_word_t;

	logic [63:0] results_due[$];
	int          mismatches;
	logic [WW-1:0] cur_width;
	bit          no_idle;
	bit          hold_req;

	width_masked_integer_alu_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.word_width_we (word_width_we),
		.word_width    (word_width),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.right_operand (right_operand),
		.left_operand  (left_operand),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result        (result)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// effective width: 0 and anything above 64 mean 64
	function automatic int unsigned eff_bits(logic [WW-1:0] w);
		if (w == 0 || w > MAX_WIDTH) return MAX_WIDTH;
		return 32'(w);
	endfunction

	function automatic logic [63:0] bits_mask(int unsigned w);
		if (w >= 64) return '1;
		return (64'd1 << w) - 64'd1;
	endfunction

	// signed quotient or remainder on 64 bit patterns, zero divisor gives 0
	function automatic logic [63:0] signed_divmod(logic [63:0] num, logic [63:0] den,
			bit rem);
		logic [63:0] nm, dm, q, r;
		nm = num[63] ? -num : num;
		dm = den[63] ? -den : den;
		if (dm == 0) return 64'd0;
		q = nm / dm;
		r = nm % dm;
		if (rem) return num[63] ? -r : r;
		return (num[63] != den[63]) ? -q : q;
	endfunction

	function automatic logic [63:0] rotate_in_width(logic [63:0] v, logic [63:0] cnt,
			int unsigned w, bit left);
		int unsigned r;
		logic [63:0] m;
		r = 32'(cnt % 64'(w));
		m = bits_mask(w);
		if (r == 0) return v & m;
		if (left) return ((v << r) | (v >> (w - r))) & m;
		return ((v >> r) | (v << (w - r))) & m;
	endfunction

	function automatic logic [63:0] alu_result(logic [WW-1:0] wreg, logic [3:0] op,
			logic [63:0] rhs, logic [63:0] lhs);
		int unsigned w;
		logic [63:0] m, a, b, r;
		w = eff_bits(wreg);
		m = bits_mask(w);
		a = rhs & m;
		b = lhs & m;
		case (op)
			OP_ADD: r = b + a;
			OP_SUB: r = b - a;
			OP_MUL: r = b * a;
			OP_DIV: r = signed_divmod(b, a, 1'b0);
			OP_AND: r = b & a;
			OP_OR:  r = b | a;
			OP_NOR: r = ~(b | a);
			OP_XOR: r = b ^ a;
			OP_SHL: r = (a >= 64) ? 64'd0 : (b << a);
			OP_SHR: r = (a >= 64) ? 64'd0 : (b >> a);
			OP_ROL: r = rotate_in_width(b, a, w, 1'b1);
			OP_ROR: r = rotate_in_width(b, a, w, 1'b0);
			OP_MOD: r = signed_divmod(b, a, 1'b1);
			OP_NOT: r = ~a;
			OP_NEG: r = -a;
			default: r = 64'd0;
		endcase
		return r & m;
	endfunction

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = 64'd0;
			1: v = '1;
			2: v = 64'h8000_0000_0000_0000;
			3: v = v >> $urandom_range(0, 63);
			4: v = 64'($urandom_range(0, 70));
			default: ;
		endcase
		return v;
	endfunction

	// one word through the input handshake; the prediction is queued at acceptance
	task automatic send_word(logic [3:0] op, logic [63:0] rhs, logic [63:0] lhs,
			bit fixed, logic [63:0] want);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		opcode        <= op;
		right_operand <= rhs;
		left_operand  <= lhs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		results_due.push_back(fixed ? want : alu_result(cur_width, op, rhs, lhs));
		@(negedge clk);
	endtask

	// width change only with the block drained
	task automatic set_width(logic [WW-1:0] w);
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		word_width_we <= 1'b1;
		word_width    <= w;
		cur_width     = w;
		@(negedge clk);
		word_width_we <= 1'b0;
	endtask

	// receiver: random stall, one long hold off when requested
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", result);
			end else begin
				want = results_due.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %h actual %h", want, result);
				end
			end
		end
	end

	initial begin
		alu_word_t table_rows[$];
		logic [WW-1:0] widths[$];
		int n;
		logic [3:0] op;
		mismatches    = 0;
		no_idle       = 1'b0;
		hold_req      = 1'b0;
		cur_width     = 7'd64;
		arst_n        = 1'b0;
		word_width_we = 1'b0;
		word_width    = 7'd64;
		in_valid      = 1'b0;
		opcode        = OP_ADD;
		right_operand = '0;
		left_operand  = '0;

		// directed rows; fixed results are read straight off the definition
		table_rows = '{
			'{OP_ADD, '1, 64'd1, 1, 64'd0},
			'{OP_SUB, 64'd1, 64'd0, 1, '1},
			'{OP_MUL, '1, '1, 1, 64'd1},
			'{OP_DIV, 64'd0, 64'd77, 1, 64'd0},
			'{OP_MOD, 64'd0, 64'd77, 1, 64'd0},
			'{OP_DIV, '1, 64'h8000_0000_0000_0000, 1, 64'h8000_0000_0000_0000},
			'{OP_MOD, '1, 64'h8000_0000_0000_0000, 1, 64'd0},
			'{OP_DIV, 64'd2, -64'd7, 1, -64'd3},
			'{OP_MOD, 64'd2, -64'd7, 1, -64'd1},
			'{OP_AND, 64'hF0F0, 64'hFF00, 0, 0},
			'{OP_OR,  64'hF0F0, 64'hFF00, 0, 0},
			'{OP_NOR, 64'd0, 64'd0, 1, '1},
			'{OP_XOR, '1, 64'h1234, 0, 0},
			'{OP_SHL, 64'd64, 64'd1, 1, 64'd0},
			'{OP_SHL, 64'd63, 64'd1, 1, 64'h8000_0000_0000_0000},
			'{OP_SHR, '1, '1, 1, 64'd0},
			'{OP_SHR, 64'd63, '1, 1, 64'd1},
			'{OP_ROL, 64'd65, 64'h8000_0000_0000_0001, 1, 64'd3},
			'{OP_ROR, 64'd64, 64'h1234, 1, 64'h1234},
			'{OP_ROR, 64'd1, 64'd1, 1, 64'h8000_0000_0000_0000},
			'{OP_NOT, 64'd0, '1, 1, '1},
			'{OP_NEG, 64'd1, 64'd0, 1, '1},
			'{4'd15, '1, '1, 1, 64'd0}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows at the reset width
		foreach (table_rows[i])
			send_word(table_rows[i].op, table_rows[i].rhs, table_rows[i].lhs,
				table_rows[i].fixed, table_rows[i].want);

		// width extremes, out of range widths and a few in between
		widths = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd8, 7'd13, 7'd32, 7'd63, 7'd64};
		foreach (widths[k]) begin
			set_width(widths[k]);
			n = (k == 1) ? 400 : 142;
			for (int j = 0; j < n; j++) begin
				// a stretch with no idling, and one long receiver hold off
				no_idle = (k == 2);
				if (k == 1 && j == 50) hold_req = 1'b1;
				// rotates and divides are slow, keep most words fast
				op = 4'($urandom_range(0, 15));
				if ((op == OP_DIV || op == OP_MOD || op == OP_ROL || op == OP_ROR)
						&& $urandom_range(0, 1))
					op = 4'($urandom_range(0, 9));
				send_word(op, rand64(), rand64(), 1'b0, 64'd0);
			end
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		while (results_due.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/wmalu_pkg.sv
hw/rtl/wmalu_front.sv
hw/rtl/wmalu_queue.sv
hw/rtl/wmalu_back.sv
hw/rtl/width_masked_integer_alu_unit.sv
tb/sv/tb_width_masked_integer_alu_unit.sv
